[hdl/assert_macros.svh]
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the sequence table block.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The property must hold at every rising clock edge outside reset.
`define ASSERT_HOLDS(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("assertion failed: property does not hold");

// The condition must never be true at a rising clock edge outside reset.
`define ASSERT_NEVER(lbl, clk, rst_n, cond) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
    else $error("assertion failed: forbidden condition seen");

`endif

[hdl/stsi_pkg.sv]
// ----------------------------------------------------------------------------
// stsi_pkg
// Types, codes and defaults shared by the sequence table modules.
// ----------------------------------------------------------------------------
package stsi_pkg;

  // Default storage geometry.
  localparam int unsigned DEPTH_DEFAULT       = 16;
  localparam int unsigned VALUE_WIDTH_DEFAULT = 32;

  // Fixed field widths of the streaming payloads.
  localparam int unsigned FUNC_W     = 3;
  localparam int unsigned POS_W      = 5;
  localparam int unsigned ITEM_W     = 32;
  localparam int unsigned IDX_W      = 4;
  localparam int unsigned CNT_W      = 5;
  localparam int unsigned CAP_W      = 5;
  localparam int unsigned IN_DATA_W  = 40;
  localparam int unsigned OUT_DATA_W = 48;

  // Capacity limit after reset.
  localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

  // Operation codes.
  typedef enum logic [FUNC_W-1:0] {
    FUNC_INSERT_AT     = 3'd0,
    FUNC_INSERT_SORTED = 3'd1,
    FUNC_ERASE         = 3'd2,
    FUNC_REMOVE_ALL    = 3'd3,
    FUNC_GET           = 3'd4,
    FUNC_SET           = 3'd5,
    FUNC_FIND          = 3'd6,
    FUNC_NONE          = 3'd7
  } func_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic capture;  // latch the operation of an input transfer
    logic apply;    // execute a single-step operation and load the result
    logic rm_step;  // erase the first live entry that matches
    logic rm_done;  // load the result of a remove-all operation
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic is_remove;  // latched operation is remove-all
    logic match_any;  // some live entry equals the latched value
  } status_t;

endpackage

[hdl/stsi_ctrl.sv]
// ----------------------------------------------------------------------------
// stsi_ctrl
// Controller state machine: sequences capture, execution, remove-all
// iterations and the result register handshake.
// ----------------------------------------------------------------------------
module stsi_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  input  stsi_pkg::status_t status_i,
  output stsi_pkg::cmd_t    cmd_o
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_EXEC,
    S_REMOVE
  } state_e;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;
  logic   slot_free;
  logic   load;

  // The result register can take a new result when empty or being drained.
  assign slot_free = !out_valid_q || out_ready_i;

  // Next state and command decode.
  always_comb begin
    state_d       = state_q;
    cmd_o         = '0;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.capture = 1'b1;
          state_d       = S_EXEC;
        end
      end
      S_EXEC: begin
        if (status_i.is_remove) begin
          state_d = S_REMOVE;
        end else if (slot_free) begin
          cmd_o.apply = 1'b1;
          state_d     = S_IDLE;
        end
      end
      S_REMOVE: begin
        if (status_i.match_any) begin
          cmd_o.rm_step = 1'b1;
        end else if (slot_free) begin
          cmd_o.rm_done = 1'b1;
          state_d       = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  assign load = cmd_o.apply || cmd_o.rm_done;

  // Output valid is set on a result load and cleared on an output transfer.
  always_comb begin
    out_valid_d = out_valid_q;
    if (load) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  // State and registered outputs.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = out_valid_q;

endmodule

[hdl/stsi_datapath.sv]
// ----------------------------------------------------------------------------
// stsi_datapath
// Entry cells with per-cell compare and shift, the live count, the capacity
// register and the result register.
// ----------------------------------------------------------------------------
module stsi_datapath #(
  parameter int unsigned DEPTH       = stsi_pkg::DEPTH_DEFAULT,
  parameter int unsigned VALUE_WIDTH = stsi_pkg::VALUE_WIDTH_DEFAULT
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  stsi_pkg::cmd_t                cmd_i,
  output stsi_pkg::status_t             status_o,
  input  logic [stsi_pkg::FUNC_W-1:0]   func_i,
  input  logic [stsi_pkg::POS_W-1:0]    position_i,
  input  logic [stsi_pkg::ITEM_W-1:0]   item_value_i,
  input  logic                          cfg_wen_i,
  input  logic [stsi_pkg::CAP_W-1:0]    cfg_wdata_i,
  output logic                          ok_o,
  output logic [stsi_pkg::IDX_W-1:0]    result_index_o,
  output logic [stsi_pkg::ITEM_W-1:0]   read_value_o,
  output logic [stsi_pkg::CNT_W-1:0]    removed_count_o,
  output logic [stsi_pkg::CNT_W-1:0]    live_count_o
);

  localparam int unsigned IW   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW   = $clog2(DEPTH + 1);
  localparam int unsigned CMPW = (CW > stsi_pkg::POS_W) ? CW : stsi_pkg::POS_W;
  localparam int unsigned SW   = (VALUE_WIDTH < stsi_pkg::ITEM_W) ? VALUE_WIDTH
                                                                  : stsi_pkg::ITEM_W;

  // Latched operation.
  stsi_pkg::func_e func_q;
  logic [CMPW-1:0] pos_q;
  logic [SW-1:0]   val_q;

  // Table state.
  logic [SW-1:0]   entries_q [DEPTH];
  logic [SW-1:0]   entries_d [DEPTH];
  logic [CW-1:0]   count_q, count_d;
  logic [CW-1:0]   removed_q, removed_d;
  logic [stsi_pkg::CAP_W-1:0] cap_q;

  // Result register.
  logic                        ok_q;
  logic [CMPW-1:0]             idx_q;
  logic [SW-1:0]               rd_q;
  logic [CMPW-1:0]             rem_q;
  logic [CMPW-1:0]             live_q;

  logic                        ok_d;
  logic [CMPW-1:0]             idx_d;
  logic [SW-1:0]               rd_d;

  // Compare results.
  logic [DEPTH-1:0] eq_vec;
  logic [DEPTH-1:0] ge_vec;
  logic [CMPW-1:0]  count_x;
  logic [CMPW-1:0]  first_eq;
  logic [CMPW-1:0]  first_ge;
  logic             any_eq;
  logic [CMPW-1:0]  ins_pos;
  logic             room;
  logic             ins_ok;
  logic             pos_ok;

  assign count_x = CMPW'(count_q);

  // Every cell compares its entry against the latched value in parallel.
  always_comb begin
    for (int i = 0; i < DEPTH; i++) begin
      eq_vec[i] = (CMPW'(i) < count_x) && (entries_q[i] == val_q);
      ge_vec[i] = (CMPW'(i) < count_x) && (val_q <= entries_q[i]);
    end
  end

  // Priority encoders for the first equal and the first not-smaller entry.
  always_comb begin
    first_eq = '0;
    first_ge = count_x;
    for (int i = DEPTH - 1; i >= 0; i--) begin
      if (eq_vec[i]) begin
        first_eq = CMPW'(i);
      end
      if (ge_vec[i]) begin
        first_ge = CMPW'(i);
      end
    end
  end

  assign any_eq  = |eq_vec;
  assign ins_pos = (func_q == stsi_pkg::FUNC_INSERT_AT) ? pos_q : first_ge;
  assign room    = (count_x < CMPW'(cap_q)) && (count_x < CMPW'(DEPTH));
  assign ins_ok  = room && (ins_pos <= count_x);
  assign pos_ok  = pos_q < count_x;

  assign status_o.is_remove = (func_q == stsi_pkg::FUNC_REMOVE_ALL);
  assign status_o.match_any = any_eq;

  // Cell updates: shift up for insert, shift down for erase and remove-all, write for set.
  always_comb begin
    entries_d = entries_q;
    count_d   = count_q;
    removed_d = removed_q;
    ok_d      = 1'b0;
    idx_d     = '0;
    rd_d      = '0;
    if (cmd_i.capture) begin
      removed_d = '0;
    end
    if (cmd_i.apply) begin
      unique case (func_q) inside
        stsi_pkg::FUNC_INSERT_AT, stsi_pkg::FUNC_INSERT_SORTED: begin
          if (ins_ok) begin
            for (int i = 1; i < DEPTH; i++) begin
              if ((CMPW'(i) > ins_pos) && (CMPW'(i) <= count_x)) begin
                entries_d[i] = entries_q[i-1];
              end
            end
            entries_d[ins_pos[IW-1:0]] = val_q;
            count_d = count_q + CW'(1);
            ok_d    = 1'b1;
            idx_d   = ins_pos;
          end
        end
        stsi_pkg::FUNC_ERASE: begin
          if (pos_ok) begin
            for (int i = 0; i < DEPTH - 1; i++) begin
              if (CMPW'(i) >= pos_q) begin
                entries_d[i] = entries_q[i+1];
              end
            end
            count_d = count_q - CW'(1);
            ok_d    = 1'b1;
            idx_d   = pos_q;
          end
        end
        stsi_pkg::FUNC_GET: begin
          if (pos_ok) begin
            rd_d  = entries_q[pos_q[IW-1:0]];
            ok_d  = 1'b1;
            idx_d = pos_q;
          end
        end
        stsi_pkg::FUNC_SET: begin
          if (pos_ok) begin
            entries_d[pos_q[IW-1:0]] = val_q;
            ok_d  = 1'b1;
            idx_d = pos_q;
          end
        end
        stsi_pkg::FUNC_FIND: begin
          ok_d  = any_eq;
          idx_d = first_eq;
        end
        default: begin
          ok_d = 1'b0;
        end
      endcase
    end
    // One matching entry leaves the table in each remove-all iteration.
    if (cmd_i.rm_step) begin
      for (int i = 0; i < DEPTH - 1; i++) begin
        if (CMPW'(i) >= first_eq) begin
          entries_d[i] = entries_q[i+1];
        end
      end
      count_d   = count_q - CW'(1);
      removed_d = removed_q + CW'(1);
    end
    if (cmd_i.rm_done) begin
      ok_d = (removed_q != '0);
    end
  end

  // Control state: count, removal tally and capacity limit.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q   <= '0;
      removed_q <= '0;
      cap_q     <= stsi_pkg::CAP_RESET;
    end else begin
      count_q   <= count_d;
      removed_q <= removed_d;
      if (cfg_wen_i) begin
        cap_q <= cfg_wdata_i;
      end
    end
  end

  // Entry cells and operation latch.
  always_ff @(posedge clk_i) begin
    entries_q <= entries_d;
    if (cmd_i.capture) begin
      func_q <= stsi_pkg::func_e'(func_i);
      pos_q  <= CMPW'(position_i);
      val_q  <= item_value_i[SW-1:0];
    end
  end

  // Result register, loaded once per operation.
  always_ff @(posedge clk_i) begin
    if (cmd_i.apply || cmd_i.rm_done) begin
      ok_q   <= ok_d;
      idx_q  <= idx_d;
      rd_q   <= rd_d;
      rem_q  <= cmd_i.rm_done ? CMPW'(removed_q) : '0;
      live_q <= CMPW'(count_d);
    end
  end

  assign ok_o            = ok_q;
  assign result_index_o  = idx_q[stsi_pkg::IDX_W-1:0];
  assign read_value_o    = stsi_pkg::ITEM_W'(rd_q);
  assign removed_count_o = rem_q[stsi_pkg::CNT_W-1:0];
  assign live_count_o    = live_q[stsi_pkg::CNT_W-1:0];

endmodule

[hdl/sequence_table_with_sorted_insert_unit.sv]
// ----------------------------------------------------------------------------
// sequence_table_with_sorted_insert_unit
// Ordered table of values with positional and sorted insert, erase,
// remove-all, get, set and find, one result per operation.
// ----------------------------------------------------------------------------
//  Channel   | Direction | Payload
//  s_axis    | in        | func, position, item_value
//  m_axis    | out       | ok, result_index, read_value, removed_count, live_count
//  cfg       | in        | capacity_limit
//
// An operation is captured from the transfer, then the entry cells compare
// and shift in parallel. Remove-all erases one match per cycle and loads
// its result once no live entry matches and the output register is free.
// Reset clears the count and sets the capacity limit to 16; entries are not
// cleared. A new transfer is taken while a result waits in the output
// register; execution holds until that register drains.
// ----------------------------------------------------------------------------
module sequence_table_with_sorted_insert_unit #(
  parameter int unsigned DEPTH       = stsi_pkg::DEPTH_DEFAULT,
  parameter int unsigned VALUE_WIDTH = stsi_pkg::VALUE_WIDTH_DEFAULT
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              s_axis_tvalid_i,
  output logic                              s_axis_tready_o,
  // [2:0] func, [7:3] position, [39:8] item_value
  input  logic [stsi_pkg::IN_DATA_W-1:0]    s_axis_tdata_i,
  output logic                              m_axis_tvalid_o,
  input  logic                              m_axis_tready_i,
  // [0] ok, [4:1] result_index, [36:5] read_value, [41:37] removed_count,
  // [46:42] live_count, [47] zero
  output logic [stsi_pkg::OUT_DATA_W-1:0]   m_axis_tdata_o,
  input  logic                              cfg_wen_i,
  input  logic [stsi_pkg::CAP_W-1:0]        cfg_wdata_i
);

  `include "assert_macros.svh"

  stsi_pkg::cmd_t    cmd;
  stsi_pkg::status_t status;

  logic                          ok;
  logic [stsi_pkg::IDX_W-1:0]    result_index;
  logic [stsi_pkg::ITEM_W-1:0]   read_value;
  logic [stsi_pkg::CNT_W-1:0]    removed_count;
  logic [stsi_pkg::CNT_W-1:0]    live_count;

  // Controller.
  stsi_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid_i),
    .in_ready_o  (s_axis_tready_o),
    .out_valid_o (m_axis_tvalid_o),
    .out_ready_i (m_axis_tready_i),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  // Datapath.
  stsi_datapath #(
    .DEPTH       (DEPTH),
    .VALUE_WIDTH (VALUE_WIDTH)
  ) u_datapath (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (cmd),
    .status_o        (status),
    .func_i          (s_axis_tdata_i[2:0]),
    .position_i      (s_axis_tdata_i[7:3]),
    .item_value_i    (s_axis_tdata_i[39:8]),
    .cfg_wen_i       (cfg_wen_i),
    .cfg_wdata_i     (cfg_wdata_i),
    .ok_o            (ok),
    .result_index_o  (result_index),
    .read_value_o    (read_value),
    .removed_count_o (removed_count),
    .live_count_o    (live_count)
  );

  // Pack the result fields, highest field first.
  assign m_axis_tdata_o = {1'b0, live_count, removed_count, read_value, result_index, ok};

  // No table work happens while a new transfer can be taken.
  `ASSERT_NEVER(busy_while_ready, clk_i, rst_ni, s_axis_tready_o && (cmd.apply || cmd.rm_step || cmd.rm_done))
  // A result is loaded only when the output register is free or draining.
  `ASSERT_HOLDS(load_into_free_slot, clk_i, rst_ni, (cmd.apply || cmd.rm_done) |-> (!m_axis_tvalid_o || m_axis_tready_i))
  // A loaded result is offered in the following cycle.
  `ASSERT_HOLDS(load_then_valid, clk_i, rst_ni, (cmd.apply || cmd.rm_done) |=> m_axis_tvalid_o)

endmodule
